FILE: hw/rtl/tun_pkg.sv
// Shared types and constants for the triangle unit normal pipeline.
// Used by every module of the block; depends on nothing.
package tun_pkg;

    // Default coordinate width; coordinates are sign extended from this width.
    localparam int COORD_BITS_DEF = 32;

    // Fixed field widths of the stream payloads.
    localparam int FIELD_BITS     = 32;
    localparam int NUM_IN_FIELDS  = 9;
    localparam int IN_TDATA_BITS  = FIELD_BITS * NUM_IN_FIELDS;
    localparam int OUT_TDATA_BITS = 3 * FIELD_BITS;

    // Result format: magnitude of each component in Q1.30, found one bit per step.
    localparam int RES_FRAC = 30;
    localparam int RES_BITS = RES_FRAC + 1;

    // Scale of m^2 in the rounding test (2r-1)^2 * S <= m^2 * 2^(2*RES_FRAC+2).
    localparam int M_SHIFT = 2 * RES_FRAC + 2;

    // Control that travels beside the data from stage to stage.
    typedef struct packed {
        logic       valid;
        logic       degen;
        logic [2:0] neg;
    } ctl_t;

endpackage

FILE: hw/rtl/tun_cross.sv
// Front end of the pipeline: edge vectors, edge products and the cross product.
// Three register stages; depends on tun_pkg.
module tun_cross #(
    parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic [tun_pkg::IN_TDATA_BITS-1:0]      vtx,
    output tun_pkg::ctl_t                          ctl,
    output logic [2:0][2*COORD_BITS:0]             mag
);

    localparam int CB = COORD_BITS;
    localparam int PB = 2 * CB;
    localparam int XB = PB + 1;
    localparam int FB = tun_pkg::FIELD_BITS;

    // Axis pairs of the cross product: component i is e1[j]*e2[k] - e1[k]*e2[j].
    localparam int AXJ [3] = '{1, 2, 0};
    localparam int AXK [3] = '{2, 0, 1};

    // Stage 1: edge vectors in sign and magnitude.
    logic [2:0][CB-1:0] e1_mag_next, e2_mag_next;
    logic [2:0]         e1_neg_next, e2_neg_next;
    logic [2:0][CB-1:0] e1_mag_reg, e2_mag_reg;
    logic [2:0]         e1_neg_reg, e2_neg_reg;
    logic               s1_valid_reg;

    always_comb
    begin
        logic [CB:0] a_s, b_s, c_s, d1, d2, t1, t2;
        a_s = '0; b_s = '0; c_s = '0; d1 = '0; d2 = '0; t1 = '0; t2 = '0;
        for (int d = 0; d < 3; d++)
        begin
            a_s = {vtx[d*FB+CB-1],     vtx[d*FB +: CB]};
            b_s = {vtx[(3+d)*FB+CB-1], vtx[(3+d)*FB +: CB]};
            c_s = {vtx[(6+d)*FB+CB-1], vtx[(6+d)*FB +: CB]};
            d1  = b_s - a_s;
            d2  = c_s - a_s;
            t1  = d1[CB] ? ('0 - d1) : d1;
            t2  = d2[CB] ? ('0 - d2) : d2;
            e1_neg_next[d] = d1[CB];
            e2_neg_next[d] = d2[CB];
            e1_mag_next[d] = t1[CB-1:0];
            e2_mag_next[d] = t2[CB-1:0];
        end
    end

    // Stage 2: the edge products p and q of each component, magnitudes and signs.
    logic [2:0][PB-1:0] p_mag_next, q_mag_next, p_mag_reg, q_mag_reg;
    logic [2:0]         p_neg_next, q_neg_next, p_neg_reg, q_neg_reg;
    logic               s2_valid_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_mag_next[i] = PB'(e1_mag_reg[AXJ[i]]) * PB'(e2_mag_reg[AXK[i]]);
            q_mag_next[i] = PB'(e1_mag_reg[AXK[i]]) * PB'(e2_mag_reg[AXJ[i]]);
            p_neg_next[i] = e1_neg_reg[AXJ[i]] ^ e2_neg_reg[AXK[i]];
            q_neg_next[i] = e1_neg_reg[AXK[i]] ^ e2_neg_reg[AXJ[i]];
        end
    end

    // Stage 3: each component p - q in sign and magnitude.
    logic [2:0][XB-1:0] x_mag_next, x_mag_reg;
    logic [2:0]         x_neg_next, x_neg_reg;
    logic               s3_valid_reg;

    always_comb
    begin
        logic [XB-1:0] sum, dpq, dqp;
        sum = '0; dpq = '0; dqp = '0;
        for (int i = 0; i < 3; i++)
        begin
            sum = XB'(p_mag_reg[i]) + XB'(q_mag_reg[i]);
            dpq = XB'(p_mag_reg[i]) - XB'(q_mag_reg[i]);
            dqp = XB'(q_mag_reg[i]) - XB'(p_mag_reg[i]);
            if (p_neg_reg[i] != q_neg_reg[i])
            begin
                x_mag_next[i] = sum;
                x_neg_next[i] = p_neg_reg[i];
            end
            else if (!dpq[XB-1])
            begin
                x_mag_next[i] = dpq;
                x_neg_next[i] = p_neg_reg[i];
            end
            else
            begin
                x_mag_next[i] = dqp;
                x_neg_next[i] = ~p_neg_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_mag_reg <= e1_mag_next;
            e2_mag_reg <= e2_mag_next;
            e1_neg_reg <= e1_neg_next;
            e2_neg_reg <= e2_neg_next;
            p_mag_reg  <= p_mag_next;
            q_mag_reg  <= q_mag_next;
            p_neg_reg  <= p_neg_next;
            q_neg_reg  <= q_neg_next;
            x_mag_reg  <= x_mag_next;
            x_neg_reg  <= x_neg_next;
        end
    end

    assign mag       = x_mag_reg;
    assign ctl.valid = s3_valid_reg;
    assign ctl.degen = 1'b0;
    assign ctl.neg   = x_neg_reg;

endmodule

FILE: hw/rtl/tun_square.sv
// Squares of the cross product components, their sum, and the start values
// of the rounding recurrence. Four register stages; depends on tun_pkg.
module tun_square #(
    parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  tun_pkg::ctl_t                         ctl_in,
    input  logic [2:0][2*COORD_BITS:0]            mag,
    output tun_pkg::ctl_t                         ctl_out,
    output logic [2:0][4*COORD_BITS+69:0]         rem,
    output logic [2:0][4*COORD_BITS+69:0]         prt,
    output logic [4*COORD_BITS+3:0]               sum_sq
);

    localparam int XB = 2 * COORD_BITS + 1;
    localparam int LO = (XB + 1) / 2;
    localparam int HB = XB - LO;
    localparam int QB = 2 * XB;
    localparam int SB = QB + 2;
    localparam int W  = QB + 68;

    // Stage 4: partial products of each magnitude split into high and low halves.
    logic [2:0][2*HB-1:0]  hh_reg;
    logic [2:0][HB+LO-1:0] hl_reg;
    logic [2:0][2*LO-1:0]  ll_reg;
    tun_pkg::ctl_t         c4_reg;
    logic                  degen_next;

    assign degen_next = (mag[0] == '0) && (mag[1] == '0) && (mag[2] == '0);

    // Stage 5: full squares.
    logic [2:0][QB-1:0] sq_next, sq_reg;
    tun_pkg::ctl_t      c5_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = (QB'(hh_reg[i]) << (2 * LO)) + (QB'(hl_reg[i]) << (LO + 1))
                       + QB'(ll_reg[i]);
        end
    end

    // Stage 6: sum of squares.
    logic [SB-1:0]      s_next, s6_reg;
    logic [2:0][QB-1:0] sq6_reg;
    tun_pkg::ctl_t      c6_reg;

    assign s_next = SB'(sq_reg[0]) + SB'(sq_reg[1]) + SB'(sq_reg[2]);

    // Stage 7: remainder m^2 * 2^M_SHIFT - S and partial term -S for r = 0.
    logic [2:0][W-1:0] rem_next, rem_reg, prt_reg;
    logic [SB-1:0]     s7_reg;
    tun_pkg::ctl_t     c7_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rem_next[i] = (W'(sq6_reg[i]) << tun_pkg::M_SHIFT) - W'(s6_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
            c7_reg <= '0;
        end
        else if (en)
        begin
            c4_reg <= '{valid: ctl_in.valid, degen: degen_next, neg: ctl_in.neg};
            c5_reg <= c4_reg;
            c6_reg <= c5_reg;
            c7_reg <= c6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                hh_reg[i]  <= (2*HB)'(mag[i][XB-1:LO]) * (2*HB)'(mag[i][XB-1:LO]);
                hl_reg[i]  <= (HB+LO)'(mag[i][XB-1:LO]) * (HB+LO)'(mag[i][LO-1:0]);
                ll_reg[i]  <= (2*LO)'(mag[i][LO-1:0]) * (2*LO)'(mag[i][LO-1:0]);
                prt_reg[i] <= '0 - W'(s6_reg);
            end
            sq_reg  <= sq_next;
            sq6_reg <= sq_reg;
            s6_reg  <= s_next;
            rem_reg <= rem_next;
            s7_reg  <= s6_reg;
        end
    end

    assign ctl_out = c7_reg;
    assign rem     = rem_reg;
    assign prt     = prt_reg;
    assign sum_sq  = s7_reg;

endmodule

FILE: hw/rtl/tun_norm_step.sv
// One stage of the bit-by-bit search for round(m * 2^30 / sqrt(S)), three lanes.
// Keeps R = m^2*2^62 - (2r-1)^2*S and P = (2r-1)*S; depends on tun_pkg.
module tun_norm_step #(
    parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF,
    parameter int BIT        = tun_pkg::RES_BITS - 1
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  tun_pkg::ctl_t                          ctl_in,
    input  logic [2:0][4*COORD_BITS+69:0]          rem_in,
    input  logic [2:0][4*COORD_BITS+69:0]          prt_in,
    input  logic [4*COORD_BITS+3:0]                sum_in,
    input  logic [2:0][tun_pkg::RES_BITS-1:0]      res_in,
    output tun_pkg::ctl_t                          ctl_out,
    output logic [2:0][4*COORD_BITS+69:0]          rem_out,
    output logic [2:0][4*COORD_BITS+69:0]          prt_out,
    output logic [4*COORD_BITS+3:0]                sum_out,
    output logic [2:0][tun_pkg::RES_BITS-1:0]      res_out
);

    localparam int W  = 4 * COORD_BITS + 70;
    localparam int RB = tun_pkg::RES_BITS;

    logic [2:0][W-1:0]  rem_next, prt_next, rem_reg, prt_reg;
    logic [2:0][RB-1:0] res_next, res_reg;
    logic [W-1:0]       s_w;
    logic [W-1:0]       test;
    logic [W-1:0]       sum_reg_w;
    logic [4*COORD_BITS+3:0] sum_reg;
    tun_pkg::ctl_t      ctl_reg;

    assign s_w = W'(sum_in);

    // Setting bit BIT of r moves 2r-1 up by 2^(BIT+1); the square grows by
    // 2^(BIT+2)*(2r-1) + 2^(2*BIT+2).
    always_comb
    begin
        test = '0;
        for (int i = 0; i < 3; i++)
        begin
            test = rem_in[i] - (prt_in[i] << (BIT + 2)) - (s_w << (2 * BIT + 2));
            if (!test[W-1])
            begin
                rem_next[i] = test;
                prt_next[i] = prt_in[i] + (s_w << (BIT + 1));
                res_next[i] = res_in[i] | (RB'(1) << BIT);
            end
            else
            begin
                rem_next[i] = rem_in[i];
                prt_next[i] = prt_in[i];
                res_next[i] = res_in[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            prt_reg <= prt_next;
            res_reg <= res_next;
            sum_reg <= sum_in;
        end
    end

    assign sum_reg_w = W'(sum_reg);
    assign ctl_out   = ctl_reg;
    assign rem_out   = rem_reg;
    assign prt_out   = prt_reg;
    assign res_out   = res_reg;
    assign sum_out   = sum_reg_w[4*COORD_BITS+3:0];

endmodule

FILE: hw/rtl/tun_out_buf.sv
// Output register with a skid stage for the result stream.
// Depends on tun_pkg for the payload width.
module tun_out_buf (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    input  logic [tun_pkg::OUT_TDATA_BITS:0]      push_data,
    output logic                                  up_ready,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [tun_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata,   // norm_x, norm_y, norm_z
    output logic [0:0]                            m_axis_tuser    // degenerate
);

    localparam int DB = tun_pkg::OUT_TDATA_BITS + 1;

    logic          out_v_reg, skid_v_reg, out_free;
    logic [DB-1:0] out_data_reg, skid_data_reg;

    assign out_free = !out_v_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_v_reg)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
            begin
                out_v_reg <= push;
            end
        end
        else if (push)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_v_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (push)
            begin
                out_data_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign up_ready      = !skid_v_reg;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_data_reg[DB-2:0];
    assign m_axis_tuser  = out_data_reg[DB-1];

endmodule

FILE: hw/rtl/triangle_unit_normal.sv
// Unit face normal of a triangle: (b-a) x (c-a) divided by its length, Q2.30.
// Takes one item per cycle while s_axis_tready is high, that is while the skid stage is empty.
// Depth is set by 7 front stages (edges, products, cross, partial squares, squares,
// sum, start values), 31 rounding search stages, one result bit each, and the output register.
// Reset (rst_n low, asynchronous) clears all valid bits; the pipeline starts empty.
// Depends on tun_pkg, tun_cross, tun_square, tun_norm_step and tun_out_buf.
module triangle_unit_normal #(
    parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (32 bits each, lowest first)
    input  logic [tun_pkg::IN_TDATA_BITS-1:0]     s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // norm_x, norm_y, norm_z (32 bits each, lowest first)
    output logic [tun_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata,
    // degenerate
    output logic [0:0]                            m_axis_tuser
);

    localparam int XB = 2 * COORD_BITS + 1;
    localparam int SB = 2 * XB + 2;
    localparam int W  = 2 * XB + 68;
    localparam int RB = tun_pkg::RES_BITS;
    localparam int FB = tun_pkg::FIELD_BITS;

    // The whole pipeline advances together. It stops only while the skid stage
    // holds an item, which happens only when the output register is stalled.
    logic en;

    tun_pkg::ctl_t      x_ctl;
    logic [2:0][XB-1:0] x_mag;

    tun_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_axis_tvalid),
        .vtx      (s_axis_tdata),
        .ctl      (x_ctl),
        .mag      (x_mag)
    );

    // Stage k of the search is fed by entry k and produces entry k+1.
    tun_pkg::ctl_t      st_ctl [0:RB];
    logic [2:0][W-1:0]  st_rem [0:RB];
    logic [2:0][W-1:0]  st_prt [0:RB];
    logic [SB-1:0]      st_sum [0:RB];
    logic [2:0][RB-1:0] st_res [0:RB];

    tun_square #(
        .COORD_BITS (COORD_BITS)
    ) u_square (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (x_ctl),
        .mag     (x_mag),
        .ctl_out (st_ctl[0]),
        .rem     (st_rem[0]),
        .prt     (st_prt[0]),
        .sum_sq  (st_sum[0])
    );

    assign st_res[0] = '0;

    // The most significant result bit is decided first.
    for (genvar k = 0; k < RB; k++)
    begin : g_step
        tun_norm_step #(
            .COORD_BITS (COORD_BITS),
            .BIT        (RB - 1 - k)
        ) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (st_ctl[k]),
            .rem_in  (st_rem[k]),
            .prt_in  (st_prt[k]),
            .sum_in  (st_sum[k]),
            .res_in  (st_res[k]),
            .ctl_out (st_ctl[k+1]),
            .rem_out (st_rem[k+1]),
            .prt_out (st_prt[k+1]),
            .sum_out (st_sum[k+1]),
            .res_out (st_res[k+1])
        );
    end

    // Final sign and the degenerate override: a zero cross product gives a zero
    // vector with the flag raised.
    logic [tun_pkg::OUT_TDATA_BITS:0] out_next;
    tun_pkg::ctl_t                    last_ctl;
    logic [2:0][RB-1:0]               last_res;

    assign last_ctl = st_ctl[RB];
    assign last_res = st_res[RB];

    always_comb
    begin
        logic [FB-1:0] v;
        v = '0;
        out_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            v = last_ctl.neg[i] ? ('0 - FB'(last_res[i])) : FB'(last_res[i]);
            out_next[i*FB +: FB] = last_ctl.degen ? '0 : v;
        end
        out_next[tun_pkg::OUT_TDATA_BITS] = last_ctl.degen;
    end

    tun_out_buf u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (last_ctl.valid && en),
        .push_data     (out_next),
        .up_ready      (en),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    assign s_axis_tready = en;

endmodule

FILE: hw/rtl/tun_check.sv
// Port-level checks for triangle_unit_normal, bound to the top level.
// Depends on tun_pkg for the payload widths.
module tun_check (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [tun_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
    input logic [0:0]                         m_axis_tuser
);

    // A degenerate triangle carries a zero vector.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("degenerate item with nonzero normal");

    // Every component of a unit vector lies within -1.0 .. 1.0 in Q2.30.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            ($signed(m_axis_tdata[31:0])  <= 32'sd1073741824) &&
            ($signed(m_axis_tdata[31:0])  >= -32'sd1073741824) &&
            ($signed(m_axis_tdata[63:32]) <= 32'sd1073741824) &&
            ($signed(m_axis_tdata[63:32]) >= -32'sd1073741824) &&
            ($signed(m_axis_tdata[95:64]) <= 32'sd1073741824) &&
            ($signed(m_axis_tdata[95:64]) >= -32'sd1073741824))
        else $error("normal component out of range");

    // The input side only stops while a finished item waits at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !$past(m_axis_tready))
        else $error("input stalled without a waiting result");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind triangle_unit_normal tun_check u_tun_check (.*);
